// ===== hdl/amo_pkg.sv =====
package amo_pkg;

  // Field widths fixed by the request format.
  localparam int unsigned OP_W   = 4;
  localparam int unsigned SLOT_W = 10;
  localparam int unsigned SIZE_W = 2;
  localparam int unsigned DATA_W = 64;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOAD  = 4'd0;
  localparam logic [OP_W-1:0] OP_STORE = 4'd1;
  localparam logic [OP_W-1:0] OP_CAS   = 4'd2;
  localparam logic [OP_W-1:0] OP_ADD   = 4'd3;
  localparam logic [OP_W-1:0] OP_SUB   = 4'd4;
  localparam logic [OP_W-1:0] OP_AND   = 4'd5;
  localparam logic [OP_W-1:0] OP_OR    = 4'd6;
  localparam logic [OP_W-1:0] OP_XOR   = 4'd7;
  localparam logic [OP_W-1:0] OP_XCHG  = 4'd8;
  localparam logic [OP_W-1:0] OP_MAX   = 4'd9;
  localparam logic [OP_W-1:0] OP_MIN   = 4'd10;
  localparam logic [OP_W-1:0] OP_UMAX  = 4'd11;
  localparam logic [OP_W-1:0] OP_UMIN  = 4'd12;

  // Access size codes.
  localparam logic [SIZE_W-1:0] SIZE_8  = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_16 = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_32 = 2'd2;
  localparam logic [SIZE_W-1:0] SIZE_64 = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;  // write zero at the clear counter and advance it
    logic issue;  // capture the request and read its memory word
    logic exec;   // compute, write back and load the result register
  } amo_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // clear counter points at the last word
    logic out_hold;  // result register is full and stalled
  } amo_sts_t;

endpackage

// ===== hdl/amo_ctrl.sv =====
module amo_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  amo_pkg::amo_sts_t sts,
  output amo_pkg::amo_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // State register; reset starts the memory clear pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.issue  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!sts.out_hold) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Requests are taken only while idle.
  assign in_stall = (state != ST_IDLE);

endmodule

// ===== hdl/amo_dp.sv =====
module amo_dp #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  amo_pkg::amo_cmd_t                   cmd,
  output amo_pkg::amo_sts_t                   sts,
  input  logic [amo_pkg::OP_W-1:0]            op,
  input  logic [amo_pkg::SLOT_W-1:0]          slot,
  input  logic [amo_pkg::SIZE_W-1:0]          access_size,
  input  logic signed [amo_pkg::DATA_W-1:0]   operand,
  input  logic signed [amo_pkg::DATA_W-1:0]   expected,
  output logic signed [amo_pkg::DATA_W-1:0]   old_value,
  output logic                                success,
  output logic                                out_valid,
  input  logic                                out_stall
);

  localparam int unsigned ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CMP_W  =
    (ADDR_W + 1 > amo_pkg::SLOT_W) ? ADDR_W + 1 : amo_pkg::SLOT_W;

  logic [amo_pkg::DATA_W-1:0] mem [SLOTS];
  logic [amo_pkg::DATA_W-1:0] rd_data;

  logic [ADDR_W-1:0]          clr_cnt;
  logic [ADDR_W-1:0]          req_addr;
  logic                       req_hit;
  logic [amo_pkg::OP_W-1:0]   req_op;
  logic [amo_pkg::SIZE_W-1:0] req_size;
  logic [amo_pkg::DATA_W-1:0] req_opnd;
  logic [amo_pkg::DATA_W-1:0] req_expc;

  logic [CMP_W-1:0]           slot_ext;
  logic [ADDR_W-1:0]          in_addr;
  logic                       in_hit;

  logic [amo_pkg::DATA_W-1:0] mask;
  logic [amo_pkg::DATA_W-1:0] cur;
  logic [amo_pkg::DATA_W-1:0] cur_s;
  logic [amo_pkg::DATA_W-1:0] opnd;
  logic [amo_pkg::DATA_W-1:0] opnd_s;
  logic [amo_pkg::DATA_W-1:0] expc;
  logic [amo_pkg::DATA_W-1:0] next_val;
  logic                       do_write;
  logic                       ok;

  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [amo_pkg::DATA_W-1:0] mem_wdata;

  // Range check of the incoming slot and its memory address.
  assign slot_ext = CMP_W'(slot);
  assign in_hit   = (slot_ext < CMP_W'(SLOTS));
  assign in_addr  = slot_ext[ADDR_W-1:0];

  // Clear pass counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign sts = '{clr_last: (clr_cnt == ADDR_W'(SLOTS - 1)),
                 out_hold: (out_valid & out_stall)};

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      req_addr <= in_addr;
      req_hit  <= in_hit;
      req_op   <= op;
      req_size <= access_size;
      req_opnd <= operand;
      req_expc <= expected;
    end
  end

  // Word memory with one write port and one registered read port.
  assign mem_we    = cmd.clear | (cmd.exec & req_hit & do_write);
  assign mem_waddr = cmd.clear ? clr_cnt : req_addr;
  assign mem_wdata = cmd.clear ? '0 : (next_val & mask);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.issue) begin
      rd_data <= mem[in_addr];
    end
  end

  // Size mask and sign extension of the old value and the operand.
  always_comb begin
    case (req_size)
      amo_pkg::SIZE_8: begin
        mask   = 64'h0000_0000_0000_00FF;
        cur_s  = {{56{rd_data[7]}}, rd_data[7:0]};
        opnd_s = {{56{req_opnd[7]}}, req_opnd[7:0]};
      end
      amo_pkg::SIZE_16: begin
        mask   = 64'h0000_0000_0000_FFFF;
        cur_s  = {{48{rd_data[15]}}, rd_data[15:0]};
        opnd_s = {{48{req_opnd[15]}}, req_opnd[15:0]};
      end
      amo_pkg::SIZE_32: begin
        mask   = 64'h0000_0000_FFFF_FFFF;
        cur_s  = {{32{rd_data[31]}}, rd_data[31:0]};
        opnd_s = {{32{req_opnd[31]}}, req_opnd[31:0]};
      end
      default: begin
        mask   = 64'hFFFF_FFFF_FFFF_FFFF;
        cur_s  = rd_data;
        opnd_s = req_opnd;
      end
    endcase
  end

  assign cur  = rd_data & mask;
  assign opnd = req_opnd & mask;
  assign expc = req_expc & mask;

  // Operation select; the written word is truncated to the access size.
  always_comb begin
    next_val = cur;
    do_write = 1'b1;
    ok       = 1'b1;
    case (req_op)
      amo_pkg::OP_STORE: next_val = opnd;
      amo_pkg::OP_CAS: begin
        if (cur == expc) begin
          next_val = opnd;
        end else begin
          do_write = 1'b0;
          ok       = 1'b0;
        end
      end
      amo_pkg::OP_ADD:  next_val = cur + opnd;
      amo_pkg::OP_SUB:  next_val = cur - opnd;
      amo_pkg::OP_AND:  next_val = cur & opnd;
      amo_pkg::OP_OR:   next_val = cur | opnd;
      amo_pkg::OP_XOR:  next_val = cur ^ opnd;
      amo_pkg::OP_XCHG: next_val = opnd;
      amo_pkg::OP_MAX:  next_val = ($signed(cur_s) > $signed(opnd_s)) ? cur : opnd;
      amo_pkg::OP_MIN:  next_val = ($signed(opnd_s) > $signed(cur_s)) ? cur : opnd;
      amo_pkg::OP_UMAX: next_val = (cur > opnd) ? cur : opnd;
      amo_pkg::OP_UMIN: next_val = (cur < opnd) ? cur : opnd;
      amo_pkg::OP_LOAD: do_write = 1'b0;
      default:          do_write = 1'b0;
    endcase
  end

  // Result register; an out-of-range slot returns zero and no success.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      old_value <= req_hit ? cur_s : '0;
      success   <= req_hit & ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== hdl/atomic_memory_op_unit.sv =====
// A request is registered and its memory word read when it is accepted;
// the result is computed, written back and registered in the execute state.
// Requests do not overlap: in_stall stays high until the execute step ends.
// A stalled result holds the next request in the execute cycle.
// Reset: synchronous; the memory is then cleared one word a cycle, all
// SLOTS words (1024 by default), with in_stall high throughout.
module atomic_memory_op_unit #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [amo_pkg::OP_W-1:0]          op,
  input  logic [amo_pkg::SLOT_W-1:0]        slot,
  input  logic [amo_pkg::SIZE_W-1:0]        access_size,
  input  logic signed [amo_pkg::DATA_W-1:0] operand,
  input  logic signed [amo_pkg::DATA_W-1:0] expected,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [amo_pkg::DATA_W-1:0] old_value,
  output logic                              success
);

  amo_pkg::amo_cmd_t cmd;
  amo_pkg::amo_sts_t sts;

  // Sequencer.
  amo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Memory and operation datapath.
  amo_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .op          (op),
    .slot        (slot),
    .access_size (access_size),
    .operand     (operand),
    .expected    (expected),
    .old_value   (old_value),
    .success     (success),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
  );

`ifndef SYNTHESIS
  // The clear pass holds off requests right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> in_stall)
    else $error("request port open during memory clear");

  // An accepted request keeps the port closed while it executes.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request accepted during execution");

  // A new result only follows a cycle in which a request was in flight.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in flight");
`endif

endmodule
